>>> src/hrht_pkg.sv
// ----------------------------------------------------------------------------
// hrht_pkg
// Types and constants for the HTTP request head tokenizer.
// ----------------------------------------------------------------------------
package hrht_pkg;

  localparam int COUNT_BITS = 16;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [3:0] PH_METHOD     = 4'd0;
  localparam logic [3:0] PH_METHOD_SP  = 4'd1;
  localparam logic [3:0] PH_URL        = 4'd2;
  localparam logic [3:0] PH_URL_SP     = 4'd3;
  localparam logic [3:0] PH_VERSION    = 4'd4;
  localparam logic [3:0] PH_SL_CR      = 4'd5;
  localparam logic [3:0] PH_LINE_START = 4'd6;
  localparam logic [3:0] PH_EMPTY_CR   = 4'd7;
  localparam logic [3:0] PH_NAME       = 4'd8;
  localparam logic [3:0] PH_NAME_SP    = 4'd9;
  localparam logic [3:0] PH_VALUE      = 4'd10;
  localparam logic [3:0] PH_HDR_CR     = 4'd11;
  localparam logic [3:0] PH_DONE       = 4'd12;
  localparam logic [3:0] PH_ERROR      = 4'd13;

  localparam logic [2:0] K_NONE    = 3'd0;
  localparam logic [2:0] K_METHOD  = 3'd1;
  localparam logic [2:0] K_URL     = 3'd2;
  localparam logic [2:0] K_VERSION = 3'd3;
  localparam logic [2:0] K_NAME    = 3'd4;
  localparam logic [2:0] K_VALUE   = 3'd5;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_METHOD_END = 3'd1;
  localparam logic [2:0] EV_URL_END    = 3'd2;
  localparam logic [2:0] EV_LINE_DONE  = 3'd3;
  localparam logic [2:0] EV_PAIR_DONE  = 3'd4;
  localparam logic [2:0] EV_HEAD_DONE  = 3'd5;
  localparam logic [2:0] EV_ERROR      = 3'd6;
  localparam logic [2:0] EV_DISCARD    = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       chunk_last;
  } tok_in_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  out_byte;
    logic [2:0]  event_res;
    logic [15:0] consumed;
  } tok_out_t;

endpackage

>>> src/http_request_head_tokenizer.sv
// An accepted request's result is registered; throughput is one byte per cycle
// when the output is not stalled. The phase and byte count registers close the loop.
// The output register is refilled in the same cycle it is drained.
// Reset (rst, synchronous): phase to method, byte count to zero, output empty.
// ----------------------------------------------------------------------------
// http_request_head_tokenizer
// Byte-serial HTTP request head tokenizer with field tagging and byte count.
// ----------------------------------------------------------------------------
module http_request_head_tokenizer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  hrht_pkg::tok_in_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output hrht_pkg::tok_out_t out_data
);
  import hrht_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS:0]   OUT_MAX = (COUNT_BITS+1)'(16'hFFFF);

  logic [3:0]            parse_phase, parse_phase_next;
  logic [COUNT_BITS-1:0] chunk_count, chunk_count_next;
  logic [3:0]            ph;
  logic [COUNT_BITS-1:0] cnt, cnt_upd;
  logic [7:0]            c;
  logic                  blank, used, accept;
  logic [2:0]            kind, ev;
  tok_out_t              res_next;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign c     = in_data.data_byte;
  assign blank = c inside {CH_SP, CH_TAB};
  assign ph    = in_data.restart ? PH_METHOD : parse_phase;
  assign cnt   = in_data.restart ? '0 : chunk_count;

  always_comb begin
    parse_phase_next = ph;
    kind = K_NONE;
    ev   = EV_NONE;
    used = 1'b1;
    case (ph)
      PH_METHOD: begin
        if (blank) begin
          parse_phase_next = PH_METHOD_SP;
          ev = EV_METHOD_END;
        end else kind = K_METHOD;
      end
      PH_METHOD_SP: begin
        if (!blank) begin
          kind = K_URL;
          parse_phase_next = PH_URL;
        end
      end
      PH_URL: begin
        if (blank) begin
          parse_phase_next = PH_URL_SP;
          ev = EV_URL_END;
        end else kind = K_URL;
      end
      PH_URL_SP: begin
        if (!blank) begin
          kind = K_VERSION;
          parse_phase_next = PH_VERSION;
        end
      end
      PH_VERSION: begin
        if (c == CH_CR) parse_phase_next = PH_SL_CR;
        else kind = K_VERSION;
      end
      PH_SL_CR: begin
        if (c == CH_LF) begin
          parse_phase_next = PH_LINE_START;
          ev = EV_LINE_DONE;
        end else begin
          parse_phase_next = PH_ERROR;
          ev = EV_ERROR;
        end
      end
      PH_LINE_START: begin
        if (c == CH_CR) parse_phase_next = PH_EMPTY_CR;
        else begin
          kind = K_NAME;
          parse_phase_next = PH_NAME;
        end
      end
      PH_EMPTY_CR: begin
        if (c == CH_LF) begin
          parse_phase_next = PH_DONE;
          ev = EV_HEAD_DONE;
        end else begin
          parse_phase_next = PH_ERROR;
          ev = EV_ERROR;
        end
      end
      PH_NAME: begin
        if (c == CH_COLON) parse_phase_next = PH_NAME_SP;
        else kind = K_NAME;
      end
      PH_NAME_SP: begin
        if (c == CH_CR) parse_phase_next = PH_HDR_CR;
        else if (!blank) begin
          kind = K_VALUE;
          parse_phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (c == CH_CR) parse_phase_next = PH_HDR_CR;
        else kind = K_VALUE;
      end
      PH_HDR_CR: begin
        if (c == CH_LF) begin
          parse_phase_next = PH_LINE_START;
          ev = EV_PAIR_DONE;
        end else begin
          parse_phase_next = PH_ERROR;
          ev = EV_ERROR;
        end
      end
      default: begin
        // done, error and unused codes: swallow the byte
        used = 1'b0;
        ev   = EV_DISCARD;
      end
    endcase
  end

  assign cnt_upd = (used && cnt != CNT_MAX) ? cnt + 1'b1 : cnt;
  assign chunk_count_next = in_data.chunk_last ? '0 : cnt_upd;

  always_comb begin
    res_next.byte_kind = kind;
    if (kind == K_NONE) res_next.out_byte = 8'h00;
    else if (kind == K_NAME && c >= 8'h41 && c <= 8'h5A) res_next.out_byte = c + 8'h20;
    else res_next.out_byte = c;
    res_next.event_res = ev;
    if (ev == EV_HEAD_DONE || in_data.chunk_last) begin
      if ((COUNT_BITS+1)'(cnt_upd) > OUT_MAX) res_next.consumed = 16'hFFFF;
      else res_next.consumed = 16'(cnt_upd);
    end else res_next.consumed = 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_METHOD;
      chunk_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        parse_phase <= parse_phase_next;
        chunk_count <= chunk_count_next;
        out_valid   <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data <= res_next;
  end

`ifndef SYNTHESIS
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output register not empty after reset");
  a_discard_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.event_res == EV_DISCARD |-> out_data.byte_kind == K_NONE)
    else $error("discarded request tagged as content");
  a_sep_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.byte_kind == K_NONE |-> out_data.out_byte == 8'h00)
    else $error("separator request carries a byte");
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    parse_phase == PH_DONE && !(accept && in_data.restart) |=> parse_phase == PH_DONE)
    else $error("parser left done without restart");
`endif

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HTTP request head tokenizer.
// A short table of directed bytes walks every phase and separator, an error
// path and the discard path. It is followed by random request heads with noise
// and random buffer ends. Every result is compared with its typed value or with
// a cycle-free predictor of the parser. Both ports idle at random, and the
// output is held off once long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import hrht_pkg::*;

  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT  = 5000;
  localparam int NDIR         = 31;

  typedef struct packed {
    tok_in_t  req;
    logic     typed;
    tok_out_t res;
  } dir_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tok_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  tok_out_t out_data;

  logic [3:0]  phase_q;
  logic [15:0] count_q;
  tok_out_t    expected_tokens [$];
  int          errors = 0;
  int          sent_items = 0;
  int          idle_cycles = 0;
  bit          steady = 1'b0;

  // directed bytes; typed rows carry their result, the others use the predictor
  dir_row_t dir_rows [NDIR] = '{
    '{'{8'h00, 1'b0, 1'b0}, 1'b1, '{K_METHOD, 8'h00, EV_NONE, 16'd0}},
    '{'{8'h47, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_TAB, 1'b0, 1'b0}, 1'b1, '{K_NONE, 8'h00, EV_METHOD_END, 16'd0}},
    '{'{CH_SP, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h2F, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_SP, 1'b0, 1'b0}, 1'b1, '{K_NONE, 8'h00, EV_URL_END, 16'd0}},
    '{'{8'h48, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_CR, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_LF, 1'b0, 1'b0}, 1'b1, '{K_NONE, 8'h00, EV_LINE_DONE, 16'd0}},
    '{'{8'h5A, 1'b0, 1'b0}, 1'b1, '{K_NAME, 8'h7A, EV_NONE, 16'd0}},
    '{'{8'h41, 1'b0, 1'b0}, 1'b1, '{K_NAME, 8'h61, EV_NONE, 16'd0}},
    '{'{CH_CR, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_COLON, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_CR, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_LF, 1'b0, 1'b0}, 1'b1, '{K_NONE, 8'h00, EV_PAIR_DONE, 16'd0}},
    '{'{8'h78, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_COLON, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_TAB, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h56, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_CR, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_LF, 1'b0, 1'b1}, 1'b1, '{K_NONE, 8'h00, EV_PAIR_DONE, 16'd21}},
    '{'{CH_CR, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_LF, 1'b0, 1'b0}, 1'b1, '{K_NONE, 8'h00, EV_HEAD_DONE, 16'd2}},
    '{'{8'h51, 1'b0, 1'b1}, 1'b1, '{K_NONE, 8'h00, EV_DISCARD, 16'd2}},
    '{'{CH_SP, 1'b1, 1'b0}, 1'b1, '{K_NONE, 8'h00, EV_METHOD_END, 16'd0}},
    '{'{8'h75, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_SP, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_CR, 1'b0, 1'b0}, 1'b0, '0},
    '{'{CH_CR, 1'b0, 1'b0}, 1'b0, '0},
    '{'{8'h51, 1'b0, 1'b0}, 1'b1, '{K_NONE, 8'h00, EV_ERROR, 16'd0}},
    '{'{8'hFF, 1'b0, 1'b1}, 1'b1, '{K_NONE, 8'h00, EV_DISCARD, 16'd6}}
  };

  http_request_head_tokenizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic tok_out_t tokenize_byte(tok_in_t req);
    tok_out_t   res;
    logic [7:0] c;
    logic [2:0] kind;
    logic [2:0] ev;
    logic       used;
    c    = req.data_byte;
    kind = K_NONE;
    ev   = EV_NONE;
    used = 1'b1;
    if (req.restart) begin
      phase_q = PH_METHOD;
      count_q = '0;
    end
    case (phase_q)
      PH_METHOD: begin
        if (is_blank(c)) begin
          phase_q = PH_METHOD_SP;
          ev = EV_METHOD_END;
        end else kind = K_METHOD;
      end
      PH_METHOD_SP: begin
        if (!is_blank(c)) begin
          kind = K_URL;
          phase_q = PH_URL;
        end
      end
      PH_URL: begin
        if (is_blank(c)) begin
          phase_q = PH_URL_SP;
          ev = EV_URL_END;
        end else kind = K_URL;
      end
      PH_URL_SP: begin
        if (!is_blank(c)) begin
          kind = K_VERSION;
          phase_q = PH_VERSION;
        end
      end
      PH_VERSION: begin
        if (c == CH_CR) phase_q = PH_SL_CR;
        else kind = K_VERSION;
      end
      PH_SL_CR: begin
        phase_q = (c == CH_LF) ? PH_LINE_START : PH_ERROR;
        ev = (c == CH_LF) ? EV_LINE_DONE : EV_ERROR;
      end
      PH_LINE_START: begin
        if (c == CH_CR) phase_q = PH_EMPTY_CR;
        else begin
          kind = K_NAME;
          phase_q = PH_NAME;
        end
      end
      PH_EMPTY_CR: begin
        phase_q = (c == CH_LF) ? PH_DONE : PH_ERROR;
        ev = (c == CH_LF) ? EV_HEAD_DONE : EV_ERROR;
      end
      PH_NAME: begin
        if (c == CH_COLON) phase_q = PH_NAME_SP;
        else kind = K_NAME;
      end
      PH_NAME_SP: begin
        if (c == CH_CR) phase_q = PH_HDR_CR;
        else if (!is_blank(c)) begin
          kind = K_VALUE;
          phase_q = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (c == CH_CR) phase_q = PH_HDR_CR;
        else kind = K_VALUE;
      end
      PH_HDR_CR: begin
        phase_q = (c == CH_LF) ? PH_LINE_START : PH_ERROR;
        ev = (c == CH_LF) ? EV_PAIR_DONE : EV_ERROR;
      end
      default: begin
        used = 1'b0;
        ev = EV_DISCARD;
      end
    endcase
    if (used && count_q != 16'hFFFF) count_q = count_q + 16'd1;
    res.byte_kind = kind;
    if (kind == K_NONE) res.out_byte = 8'h00;
    else if (kind == K_NAME && c >= 8'h41 && c <= 8'h5A) res.out_byte = c + 8'h20;
    else res.out_byte = c;
    res.event_res = ev;
    res.consumed  = (ev == EV_HEAD_DONE || req.chunk_last) ? count_q : 16'h0000;
    if (req.chunk_last) count_q = '0;
    return res;
  endfunction

  function automatic logic [7:0] pick_byte(logic [7:0] x0, logic [7:0] x1, logic [7:0] x2);
    logic [7:0] b;
    do begin
      if ($urandom_range(1) == 1) b = 8'h41 + 8'($urandom_range(25));
      else b = 8'($urandom_range(255));
    end while (b == x0 || b == x1 || b == x2);
    return b;
  endfunction

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(1) == 1) ? CH_SP : CH_TAB;
  endfunction

  task automatic send_request(tok_in_t req, logic typed, tok_out_t typed_res);
    tok_out_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = tokenize_byte(req);
    expected_tokens.insert(expected_tokens.size(), typed ? typed_res : res);
  endtask

  task automatic send_byte(logic [7:0] c, bit first, bit counted);
    tok_in_t req;
    req.data_byte  = ($urandom_range(99) < 3) ? 8'($urandom_range(255)) : c;
    req.restart    = first ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0);
    req.chunk_last = ($urandom_range(11) == 0);
    if (counted) sent_items++;
    send_request(req, 1'b0, '0);
  endtask

  task automatic send_head();
    send_byte(pick_byte(CH_SP, CH_TAB, CH_TAB), 1'b1, 1'b1);
    repeat ($urandom_range(5)) send_byte(pick_byte(CH_SP, CH_TAB, CH_TAB), 1'b0, 1'b1);
    repeat ($urandom_range(2, 1)) send_byte(pick_blank(), 1'b0, 1'b1);
    repeat ($urandom_range(8, 1)) send_byte(pick_byte(CH_SP, CH_TAB, CH_TAB), 1'b0, 1'b1);
    repeat ($urandom_range(2, 1)) send_byte(pick_blank(), 1'b0, 1'b1);
    send_byte(pick_byte(CH_CR, CH_SP, CH_TAB), 1'b0, 1'b1);
    repeat ($urandom_range(7)) send_byte(pick_byte(CH_CR, CH_CR, CH_CR), 1'b0, 1'b1);
    send_byte(CH_CR, 1'b0, 1'b1);
    send_byte(CH_LF, 1'b0, 1'b1);
    repeat ($urandom_range(4)) begin
      repeat ($urandom_range(6, 1)) send_byte(pick_byte(CH_COLON, CH_CR, CH_CR), 1'b0, 1'b1);
      send_byte(CH_COLON, 1'b0, 1'b1);
      repeat ($urandom_range(2)) send_byte(pick_blank(), 1'b0, 1'b1);
      if ($urandom_range(3) != 0) begin
        send_byte(pick_byte(CH_CR, CH_SP, CH_TAB), 1'b0, 1'b1);
        repeat ($urandom_range(5)) send_byte(pick_byte(CH_CR, CH_CR, CH_CR), 1'b0, 1'b1);
      end
      send_byte(CH_CR, 1'b0, 1'b1);
      send_byte(CH_LF, 1'b0, 1'b1);
    end
    send_byte(CH_CR, 1'b0, 1'b1);
    send_byte(CH_LF, 1'b0, 1'b1);
    // trailing bytes land in the discard path
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(3, 1)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  task automatic check_token(tok_out_t exp_tok, tok_out_t got);
    if (got.byte_kind !== exp_tok.byte_kind) begin
      $error("byte_kind: expected %0d, got %0d", exp_tok.byte_kind, got.byte_kind);
      errors++;
    end
    if (got.out_byte !== exp_tok.out_byte) begin
      $error("out_byte: expected %0h, got %0h", exp_tok.out_byte, got.out_byte);
      errors++;
    end
    if (got.event_res !== exp_tok.event_res) begin
      $error("event_res: expected %0d, got %0d", exp_tok.event_res, got.event_res);
      errors++;
    end
    if (got.consumed !== exp_tok.consumed) begin
      $error("consumed: expected %0d, got %0d", exp_tok.consumed, got.consumed);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("result with no request pending: %0h", out_data);
        errors++;
      end else check_token(expected_tokens.pop_front(), out_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // output side: random stalls, one long hold-off to back up the input
  initial begin : receiver
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_items >= 300) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (steady) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin : stimulus
    phase_q = PH_METHOD;
    count_q = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NDIR; i++)
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    while (sent_items < RANDOM_ITEMS) begin
      steady = (sent_items >= 500 && sent_items < 700);
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(20, 5)) send_byte(8'($urandom_range(255)), 1'b0, 1'b1);
      else send_head();
    end
    steady = 1'b0;
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
src/hrht_pkg.sv
src/http_request_head_tokenizer.sv
tb/sv/tb.sv
